// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; clock and reset names follow the project ports
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition now implies consequence now
`define WHS_ASSERT_IMPL(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("whs assertion failed");

// condition now implies consequence in the next cycle
`define WHS_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("whs assertion failed");

`endif

// ===== sv/whs_pkg.sv =====
// constants, types and state codes for the window histogram block
// no dependencies
package whs_pkg;

   localparam int Window    = 300;
   localparam int Bins      = 50;
   localparam int AddrW     = 9;
   localparam int CountW    = 9;
   localparam int BinW      = 6;
   localparam int DivW      = 73;
   localparam int DivCntW   = 7;
   localparam int DivisorW  = 32;

   // reciprocal of the bin count, exact for any 32 bit range
   localparam logic [31:0] RangeRecip = 32'h51EB_851F;
   localparam int          RangeShift = 36;

   localparam logic [DivCntW-1:0] MeanBits  = 7'd41;
   localparam logic [DivCntW-1:0] IndexBits = 7'd38;
   localparam logic [DivCntW-1:0] VarBits   = 7'd73;
   localparam logic [DivCntW-1:0] FracBits  = 7'd25;

   typedef struct packed {
      logic               start;
      logic [DivCntW-1:0] nbits;
   } div_req_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_MEAN_GO,
      ST_MEAN,
      ST_RANGE_GO,
      ST_RANGE,
      ST_BRD,
      ST_BDAT,
      ST_BDIV,
      ST_BCRD,
      ST_BCWR,
      ST_VAR_GO,
      ST_VAR,
      ST_SQRT,
      ST_ORD,
      ST_OGO,
      ST_ODIV,
      ST_OSEND
   } state_type;

endpackage

// ===== sv/whs_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on whs_pkg
module whs_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  whs_pkg::div_req_type         div_req,
   input  logic [whs_pkg::DivW-1:0]     dividend,
   input  logic [whs_pkg::DivisorW-1:0] divisor,
   output logic [whs_pkg::DivW-1:0]     quotient,
   output logic                         done
);
   import whs_pkg::*;

   logic [DivW-1:0]     dvd_ff, dvd_in;
   logic [DivisorW-1:0] dvs_ff, dvs_in;
   logic [DivW-1:0]     quo_ff, quo_in;
   logic [DivisorW-1:0] rem_ff, rem_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivisorW:0]   rem_sh;

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, dvd_ff[cnt_ff - 7'd1]};
      if (div_req.start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = div_req.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = DivisorW'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DivisorW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign done      = done_ff;

endmodule

// ===== sv/whs_isqrt.sv =====
// integer square root, one result bit per cycle
// depends on whs_pkg
module whs_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);
   import whs_pkg::*;

   logic [63:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[33:0], rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// ===== sv/window_histogram_and_stats.sv =====
// top level: sample ring memory, bin count memory and report sequencer
// depends on whs_pkg, whs_divider, whs_isqrt and assert_macros.svh
//
// usage
//  req channel: one sample transaction per cycle while idle; req_last closes the set
//  rsp channel: 50 bin transactions in rising bin order after a closing sample,
//    the last one with rsp_final_res high and the mean, variance and deviation
//  report: a closing sample starts the count clear, the min/max/sum scan,
//    the mean, the range split and the binning of the n samples held
//    (at most 300), then, for n of two or more, the variance and its root,
//    and last the fractions
//  throughput: one sample per cycle between reports; req_stall is high
//    for the whole report, whenever the sequencer is not idle
//  stall: while rsp_stall is high the current bin transaction holds and the
//    report waits; the next bin is prepared only after it is taken
//  reset: ring and counters empty, no report pending; the sample memory
//    itself is not cleared and entries are read only after being written
module window_histogram_and_stats (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [31:0]          req_sample,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [whs_pkg::BinW-1:0]    rsp_bin_number,
   output logic signed [31:0]          rsp_bin_low,
   output logic signed [31:0]          rsp_bin_high,
   output logic [16:0]                 rsp_fraction,
   output logic signed [31:0]          rsp_mean_value,
   output logic [62:0]                 rsp_sample_variance,
   output logic [31:0]                 rsp_std_deviation,
   output logic                        rsp_final_res
);
   import whs_pkg::*;
   `include "assert_macros.svh"

   localparam logic [AddrW-1:0] WinLast = AddrW'(Window);
   localparam logic [BinW-1:0]  BinTop  = BinW'(Bins - 1);
   localparam logic [6:0]       BinsC   = 7'(Bins);

   // memories
   logic signed [31:0] win_mem [Window];
   logic [CountW-1:0]  cnt_mem [Bins];
   logic signed [31:0] win_rd_ff;
   logic [CountW-1:0]  cnt_rd_ff;
   logic               win_we;
   logic [AddrW-1:0]   win_wa, win_ra;
   logic               cnt_we;
   logic [BinW-1:0]    cnt_wa, cnt_ra;
   logic [CountW-1:0]  cnt_wd;

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_wa] <= req_sample;
      end
      win_rd_ff <= win_mem[win_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   // control and datapath registers
   state_type          state_ff, state_in;
   logic [AddrW-1:0]   wp_ff, wp_in;
   logic [AddrW-1:0]   fill_ff, fill_in;
   logic [AddrW-1:0]   n_ff, n_in;
   logic [AddrW-1:0]   addr_ff, addr_in;
   logic               dv_ff, dv_in;
   logic               first_ff, first_in;
   logic signed [31:0] min_ff, min_in;
   logic signed [31:0] max_ff, max_in;
   logic signed [40:0] sum_ff, sum_in;
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0]        range_ff, range_in;
   logic [31:0]        rq_ff, rq_in;
   logic [BinW-1:0]    rr_ff, rr_in;
   logic [63:0]        sq_ff, sq_in;
   logic [DivW-1:0]    acc_ff, acc_in;
   logic [BinW-1:0]    idx_ff, idx_in;
   logic [62:0]        var_ff, var_in;
   logic [31:0]        sd_ff, sd_in;
   logic [BinW-1:0]    bin_ff, bin_in;
   logic [31:0]        qlo_ff, qlo_in;
   logic [31:0]        qhi_ff, qhi_in;
   logic [BinW-1:0]    rhi_ff, rhi_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BinW-1:0]    o_bin_ff, o_bin_in;
   logic [31:0]        o_low_ff, o_low_in;
   logic [31:0]        o_high_ff, o_high_in;
   logic [16:0]        o_frac_ff, o_frac_in;
   logic [31:0]        o_mean_ff, o_mean_in;
   logic [62:0]        o_var_ff, o_var_in;
   logic [31:0]        o_sd_ff, o_sd_in;
   logic               o_fin_ff, o_fin_in;

   // shared divider and square root unit
   div_req_type        div_req;
   logic [DivW-1:0]    div_dvd;
   logic [31:0]        div_dvs;
   logic [DivW-1:0]    div_q;
   logic               div_done;
   logic               sq_start;
   logic [63:0]        sq_rad;
   logic [31:0]        sq_root;
   logic               sq_done;

   whs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .quotient  (div_q),
      .done      (div_done)
   );

   whs_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .root     (sq_root),
      .done     (sq_done)
   );

   logic               accept;
   logic [40:0]        sum_mag;
   logic [32:0]        dev;
   logic [31:0]        dev_abs;
   logic [31:0]        min_off;
   logic [6:0]         rsum;
   logic [31:0]        mean_q;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign sum_mag   = sum_ff[40] ? 41'(-sum_ff) : 41'(sum_ff);
   assign dev       = {win_rd_ff[31], win_rd_ff} - {mean_ff[31], mean_ff};
   assign dev_abs   = dev[32] ? 32'(-dev) : dev[31:0];
   assign min_off   = 32'(win_rd_ff - min_ff);
   assign rsum      = {1'b0, rhi_ff} + {1'b0, rr_ff};
   assign mean_q    = div_q[31:0];

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      n_in         = n_ff;
      addr_in      = addr_ff;
      dv_in        = 1'b0;
      first_in     = first_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      range_in     = range_ff;
      rq_in        = rq_ff;
      rr_in        = rr_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      var_in       = var_ff;
      sd_in        = sd_ff;
      bin_in       = bin_ff;
      qlo_in       = qlo_ff;
      qhi_in       = qhi_ff;
      rhi_in       = rhi_ff;
      rsp_valid_in = rsp_valid_ff;
      o_bin_in     = o_bin_ff;
      o_low_in     = o_low_ff;
      o_high_in    = o_high_ff;
      o_frac_in    = o_frac_ff;
      o_mean_in    = o_mean_ff;
      o_var_in     = o_var_ff;
      o_sd_in      = o_sd_ff;
      o_fin_in     = o_fin_ff;
      win_we       = 1'b0;
      win_wa       = wp_ff;
      win_ra       = addr_ff;
      cnt_we       = 1'b0;
      cnt_wa       = idx_ff;
      cnt_wd       = '0;
      cnt_ra       = idx_ff;
      div_req      = '{start: 1'b0, nbits: MeanBits};
      div_dvd      = '0;
      div_dvs      = '0;
      sq_start     = 1'b0;
      sq_rad       = div_q[63:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               win_we  = 1'b1;
               wp_in   = (wp_ff + 9'd1 == WinLast) ? '0 : AddrW'(wp_ff + 9'd1);
               fill_in = (fill_ff < WinLast) ? AddrW'(fill_ff + 9'd1) : fill_ff;
               if (req_last) begin
                  n_in     = (fill_ff < WinLast) ? AddrW'(fill_ff + 9'd1) : fill_ff;
                  wp_in    = '0;
                  fill_in  = '0;
                  addr_in  = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = addr_ff[BinW-1:0];
            cnt_wd = '0;
            if (addr_ff == AddrW'(Bins - 1)) begin
               addr_in  = '0;
               first_in = 1'b1;
               sum_in   = '0;
               state_in = ST_SCAN;
            end else begin
               addr_in = AddrW'(addr_ff + 9'd1);
            end
         end
         ST_SCAN: begin
            if (addr_ff != n_ff) begin
               addr_in = AddrW'(addr_ff + 9'd1);
               dv_in   = 1'b1;
            end
            if (dv_ff) begin
               first_in = 1'b0;
               sum_in   = sum_ff + {{9{win_rd_ff[31]}}, win_rd_ff};
               if (first_ff || win_rd_ff < min_ff) begin
                  min_in = win_rd_ff;
               end
               if (first_ff || win_rd_ff > max_ff) begin
                  max_in = win_rd_ff;
               end
            end else if (addr_ff == n_ff) begin
               range_in = 32'({max_ff[31], max_ff} - {min_ff[31], min_ff});
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: begin
            div_req  = '{start: 1'b1, nbits: MeanBits};
            div_dvd  = DivW'(sum_mag + (sum_ff[40] ? 41'(n_ff - 9'd1) : 41'd0));
            div_dvs  = 32'(n_ff);
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               mean_in  = sum_ff[40] ? 32'(-mean_q) : mean_q;
               state_in = ST_RANGE_GO;
            end
         end
         ST_RANGE_GO: begin
            // quotient by reciprocal multiplication
            rq_in    = 32'((64'(range_ff) * 64'(RangeRecip)) >> RangeShift);
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            rr_in    = BinW'(range_ff - 32'(rq_ff * 32'(Bins)));
            addr_in  = '0;
            acc_in   = '0;
            state_in = ST_BRD;
         end
         ST_BRD: begin
            win_ra   = addr_ff;
            state_in = ST_BDAT;
         end
         ST_BDAT: begin
            sq_in = 64'(dev_abs) * 64'(dev_abs);
            if (win_rd_ff == max_ff || range_ff == '0) begin
               idx_in   = BinTop;
               state_in = ST_BCRD;
            end else begin
               div_req  = '{start: 1'b1, nbits: IndexBits};
               div_dvd  = DivW'({6'd0, min_off} * 38'(Bins));
               div_dvs  = range_ff;
               state_in = ST_BDIV;
            end
         end
         ST_BDIV: begin
            if (div_done) begin
               idx_in   = (div_q > DivW'(Bins - 1)) ? BinTop : div_q[BinW-1:0];
               state_in = ST_BCRD;
            end
         end
         ST_BCRD: begin
            cnt_ra   = idx_ff;
            acc_in   = acc_ff + DivW'(sq_ff);
            state_in = ST_BCWR;
         end
         ST_BCWR: begin
            cnt_we  = 1'b1;
            cnt_wa  = idx_ff;
            cnt_wd  = CountW'(cnt_rd_ff + 9'd1);
            addr_in = AddrW'(addr_ff + 9'd1);
            if (AddrW'(addr_ff + 9'd1) == n_ff) begin
               if (n_ff < 9'd2) begin
                  var_in   = '0;
                  sd_in    = '0;
                  bin_in   = '0;
                  qlo_in   = '0;
                  qhi_in   = rq_ff;
                  rhi_in   = rr_ff;
                  state_in = ST_ORD;
               end else begin
                  state_in = ST_VAR_GO;
               end
            end else begin
               state_in = ST_BRD;
            end
         end
         ST_VAR_GO: begin
            div_req  = '{start: 1'b1, nbits: VarBits};
            div_dvd  = acc_ff;
            div_dvs  = 32'(n_ff - 9'd1);
            state_in = ST_VAR;
         end
         ST_VAR: begin
            if (div_done) begin
               var_in = 63'(div_q >> 16);
               bin_in = '0;
               qlo_in = '0;
               qhi_in = rq_ff;
               rhi_in = rr_ff;
               if (div_q[DivW-1:64] != '0) begin
                  sd_in    = 32'hFFFF_FFFF;
                  state_in = ST_ORD;
               end else begin
                  sq_start = 1'b1;
                  sq_rad   = div_q[63:0];
                  state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               sd_in    = sq_root;
               state_in = ST_ORD;
            end
         end
         ST_ORD: begin
            cnt_ra   = bin_ff;
            state_in = ST_OGO;
         end
         ST_OGO: begin
            div_req  = '{start: 1'b1, nbits: FracBits};
            div_dvd  = DivW'({cnt_rd_ff, 16'd0}) + DivW'(n_ff >> 1);
            div_dvs  = 32'(n_ff);
            state_in = ST_ODIV;
         end
         ST_ODIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               o_bin_in     = bin_ff;
               o_low_in     = 32'(min_ff + qlo_ff);
               o_high_in    = 32'(min_ff + qhi_ff);
               o_frac_in    = div_q[16:0];
               o_fin_in     = (bin_ff == BinTop);
               o_mean_in    = (bin_ff == BinTop) ? mean_ff : '0;
               o_var_in     = (bin_ff == BinTop) ? var_ff : '0;
               o_sd_in      = (bin_ff == BinTop) ? sd_ff : '0;
               state_in     = ST_OSEND;
            end
         end
         ST_OSEND: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (bin_ff == BinTop) begin
                  state_in = ST_IDLE;
               end else begin
                  bin_in = BinW'(bin_ff + 6'd1);
                  qlo_in = qhi_ff;
                  if (rsum >= BinsC) begin
                     rhi_in = BinW'(rsum - BinsC);
                     qhi_in = 32'(qhi_ff + rq_ff + 32'd1);
                  end else begin
                     rhi_in = rsum[BinW-1:0];
                     qhi_in = 32'(qhi_ff + rq_ff);
                  end
                  state_in = ST_ORD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff      <= n_in;
      addr_ff   <= addr_in;
      first_ff  <= first_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      sum_ff    <= sum_in;
      mean_ff   <= mean_in;
      range_ff  <= range_in;
      rq_ff     <= rq_in;
      rr_ff     <= rr_in;
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      idx_ff    <= idx_in;
      var_ff    <= var_in;
      sd_ff     <= sd_in;
      bin_ff    <= bin_in;
      qlo_ff    <= qlo_in;
      qhi_ff    <= qhi_in;
      rhi_ff    <= rhi_in;
      o_bin_ff  <= o_bin_in;
      o_low_ff  <= o_low_in;
      o_high_ff <= o_high_in;
      o_frac_ff <= o_frac_in;
      o_mean_ff <= o_mean_in;
      o_var_ff  <= o_var_in;
      o_sd_ff   <= o_sd_in;
      o_fin_ff  <= o_fin_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bin_number      = o_bin_ff;
   assign rsp_bin_low         = o_low_ff;
   assign rsp_bin_high        = o_high_ff;
   assign rsp_fraction        = o_frac_ff;
   assign rsp_mean_value      = o_mean_ff;
   assign rsp_sample_variance = o_var_ff;
   assign rsp_std_deviation   = o_sd_ff;
   assign rsp_final_res       = o_fin_ff;

   `WHS_ASSERT_IMPL(a_final_top_bin, rsp_valid && rsp_final_res, rsp_bin_number == BinTop)
   `WHS_ASSERT_IMPL(a_no_req_in_report, rsp_valid, req_stall)
   `WHS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= WinLast && wp_ff < WinLast)
   `WHS_ASSERT_NEXT(a_last_starts_report, accept && req_last, state_ff == ST_CLEAR)

endmodule

// ===== dv/tb.sv =====
// testbench for window_histogram_and_stats: directed and random sample sets
// checked against an in-bench histogram and statistics predictor; needs whs_pkg
`timescale 1ns / 100ps
module tb;
   import whs_pkg::*;

   typedef struct {
      logic [BinW-1:0]    bin;
      logic signed [31:0] low_edge;
      logic signed [31:0] high_edge;
      logic [16:0]        frac;
      logic signed [31:0] mean;
      logic [62:0]        variance;
      logic [31:0]        deviation;
      logic               final_bin;
   } bin_report_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_sample = 0;
   logic               req_last = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [BinW-1:0]    rsp_bin_number;
   logic signed [31:0] rsp_bin_low;
   logic signed [31:0] rsp_bin_high;
   logic [16:0]        rsp_fraction;
   logic signed [31:0] rsp_mean_value;
   logic [62:0]        rsp_sample_variance;
   logic [31:0]        rsp_std_deviation;
   logic               rsp_final_res;

   bin_report_type     expected_bins[$];
   logic signed [31:0] ring[Window];
   int                 ring_ptr = 0;
   int                 ring_fill = 0;
   int                 errors = 0;
   int                 samples_sent = 0;
   int                 sets_closed = 0;
   int                 bins_seen = 0;
   bit                 quiet = 0;
   int                 stall_left = 0;

   window_histogram_and_stats uut (.*);

   always #1 clock = ~clock;

   initial begin
      #3_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // histogram and statistics of the held samples, one expectation per bin
   task automatic predict_histogram();
      int              n, k, idx;
      int              counts[Bins];
      longint          mn, mx, total, mean, dev;
      longint unsigned span, a, e;
      logic [127:0]    sq_sum, quot;
      bin_report_type  r;
      n = ring_fill;
      mn = ring[0];
      mx = ring[0];
      total = 0;
      sq_sum = 0;
      for (k = 0; k < n; k++) begin
         if (ring[k] < mn) mn = ring[k];
         if (ring[k] > mx) mx = ring[k];
         total += ring[k];
      end
      span = mx - mn;
      foreach (counts[j]) counts[j] = 0;
      for (k = 0; k < n; k++) begin
         if (ring[k] == mx || span == 0) begin
            idx = Bins - 1;
         end else begin
            e = (longint'(ring[k]) - mn) * Bins / span;
            idx = (e > Bins - 1) ? Bins - 1 : int'(e);
         end
         counts[idx]++;
      end
      if (total >= 0) mean = total / n;
      else mean = -((-total + n - 1) / n);
      for (k = 0; k < n; k++) begin
         dev = longint'(ring[k]) - mean;
         a = (dev < 0) ? -dev : dev;
         sq_sum += 128'(a * a);
      end
      for (k = 0; k < Bins; k++) begin
         r.bin = BinW'(k);
         e = longint'(k) * span / Bins;
         r.low_edge = 32'(mn + longint'(e));
         e = longint'(k + 1) * span / Bins;
         r.high_edge = 32'(mn + longint'(e));
         r.frac = 17'((longint'(counts[k]) * 65536 + n / 2) / n);
         r.final_bin = (k == Bins - 1);
         r.mean = 0;
         r.variance = 0;
         r.deviation = 0;
         if (r.final_bin) begin
            r.mean = 32'(mean);
            if (n >= 2) begin
               quot = sq_sum / (n - 1);
               r.variance = (quot[127:79] != 0) ? {63{1'b1}} : quot[78:16];
               r.deviation = (quot[127:64] != 0) ? 32'hffff_ffff
                                                 : 32'(int_sqrt(quot[63:0]));
            end
         end
         expected_bins.insert(expected_bins.size(), r);
      end
      ring_ptr = 0;
      ring_fill = 0;
      sets_closed++;
   endtask

   // one sample transaction, with an occasional sender gap in front
   task automatic send_sample(input logic signed [31:0] value, input logic closing);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1;
      req_sample = value;
      req_last = closing;
      do @(posedge clock); while (req_stall);
      ring[ring_ptr] = value;
      ring_ptr = (ring_ptr + 1 >= Window) ? 0 : ring_ptr + 1;
      if (ring_fill < Window) ring_fill++;
      samples_sent++;
      if (closing) predict_histogram();
   endtask

   task automatic end_of_burst();
      @(negedge clock);
      req_valid = 0;
      req_last = 0;
   endtask

   task automatic wait_drained();
      end_of_burst();
      while (expected_bins.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_sample(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 400)) - 200;
         2: return 32'h0001_0000 * ($signed($urandom_range(0, 20)) - 10);
         default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                              : 32'h8000_0000 + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic test_single_sample();
      send_sample(32'sh8000_0000, 1);
      send_sample(32'sh7fff_ffff, 1);
   endtask

   task automatic test_extremes();
      send_sample(32'sh7fff_ffff, 0);
      send_sample(32'sh8000_0000, 0);
      send_sample(0, 1);
   endtask

   task automatic test_all_equal();
      repeat (4) send_sample(32'sh0005_0000, 0);
      send_sample(32'sh0005_0000, 1);
   endtask

   task automatic test_negative_mean();
      send_sample(-3, 0);
      send_sample(-2, 0);
      send_sample(-2, 1);
   endtask

   // sender holds off until the whole report is out
   task automatic test_drain_pause();
      send_sample(32'sh0000_1234, 0);
      send_sample(-32'sh0003_0000, 0);
      send_sample(32'sh0010_0000, 0);
      send_sample(32'sh0010_0000, 1);
      wait_drained();
   endtask

   task automatic test_overfull_window();
      int mode;
      mode = $urandom_range(0, 3);
      repeat (Window) send_sample(random_sample(mode), 0);
      send_sample(random_sample(mode), 1);
   endtask

   task automatic test_random_sets(input int sets);
      int len, mode;
      repeat (sets) begin
         len = $urandom_range(1, 3);
         mode = $urandom_range(0, 3);
         repeat (len - 1) send_sample(random_sample(mode), 0);
         send_sample(random_sample(mode), 1);
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
   endtask

   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      bin_report_type r;
      if (!reset && rsp_valid && !rsp_stall) begin
         bins_seen++;
         if (expected_bins.size() == 0) begin
            $error("unexpected bin transaction %0d", rsp_bin_number);
            errors++;
         end else begin
            r = expected_bins.pop_front();
            if (rsp_bin_number !== r.bin) begin
               $error("bin_number exp %0d got %0d", r.bin, rsp_bin_number);
               errors++;
            end
            if (rsp_bin_low !== r.low_edge) begin
               $error("bin_low exp %0d got %0d", r.low_edge, rsp_bin_low);
               errors++;
            end
            if (rsp_bin_high !== r.high_edge) begin
               $error("bin_high exp %0d got %0d", r.high_edge, rsp_bin_high);
               errors++;
            end
            if (rsp_fraction !== r.frac) begin
               $error("fraction exp %0d got %0d", r.frac, rsp_fraction);
               errors++;
            end
            if (rsp_mean_value !== r.mean) begin
               $error("mean_value exp %0d got %0d", r.mean, rsp_mean_value);
               errors++;
            end
            if (rsp_sample_variance !== r.variance) begin
               $error("sample_variance exp %0d got %0d", r.variance, rsp_sample_variance);
               errors++;
            end
            if (rsp_std_deviation !== r.deviation) begin
               $error("std_deviation exp %0d got %0d", r.deviation, rsp_std_deviation);
               errors++;
            end
            if (rsp_final_res !== r.final_bin) begin
               $error("final_res exp %0d got %0d", r.final_bin, rsp_final_res);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_single_sample();
      test_extremes();
      test_all_equal();
      test_negative_mean();
      test_drain_pause();
      test_random_sets(3);
      test_overfull_window();
      test_random_sets(2);
      wait_drained();
      quiet = 1;
      test_random_sets(2);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d samples in %0d sets, %0d bin transactions checked",
               samples_sent, sets_closed, bins_seen);
      $display("including single, equal, extreme and overfull windows");
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
